@@ rtl/rtt_pkg.sv @@
package rtt_pkg;

   localparam int TILE_ROWS        = 32;
   localparam int TILE_ROW_BYTES   = 4;
   localparam int MAX_TILES_ACROSS = 64;

   localparam int TILE_BYTES = TILE_ROWS * TILE_ROW_BYTES;
   localparam int BANK_BYTES = MAX_TILES_ACROSS * TILE_BYTES;
   localparam int STORE_BYTES = 2 * BANK_BYTES;

   localparam int COL_W      = (TILE_ROW_BYTES > 1) ? $clog2(TILE_ROW_BYTES) : 1;
   localparam int ROW_W      = $clog2(TILE_ROWS);
   localparam int TILE_W     = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
   localparam int TILES_W    = $clog2(MAX_TILES_ACROSS + 1);
   localparam int DRAIN_W    = $clog2(BANK_BYTES);
   localparam int BAND_LEN_W = $clog2(BANK_BYTES + 1);
   localparam int ADDR_W     = $clog2(STORE_BYTES);
   localparam int CSR_W      = 7;

   localparam logic [CSR_W-1:0] TILES_ACROSS_RESET = CSR_W'(16);

   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] pixel_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       band_last;
   } rsp_type;

endpackage

@@ rtl/raster_to_tile_reorder_top.sv @@
// raster-to-tile reorder buffer for a 1-bit bitmap
//
// req channel: one transfer per item; cmd selects a raster data byte or a
// drain tick. every item pulls the next byte of the last finished band, if
// one is pending; a data byte is also written into the filling band bank.
// rsp channel: out_byte in tile-major order, band_last on a band's final byte.
// csr port: csr_wr_en/csr_wr_data write tiles_across (0 acts as 1, values
// above 64 act as 64); write it only while the block is idle.
//
// throughput: one item per cycle while req_stall is low. a pulled byte
// passes the band memory read register, then the output register, before it
// reaches rsp_data. the band memory has one write and one read port, and the
// read and write in a cycle always hit opposite banks.
// when rsp_stall is held, the output register and the read register both
// fill and req_stall then rises; nothing is lost or repeated.
// reset (synchronous, active high) empties the pipeline and clears the fill
// and drain position; band memory contents stay undefined until written.
module raster_to_tile_reorder_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rtt_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rtt_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [rtt_pkg::CSR_W-1:0]          csr_wr_data
);

   logic [rtt_pkg::CSR_W-1:0]      tiles_across_ff;
   logic [rtt_pkg::TILE_W-1:0]     fill_tile_ff, fill_tile_in;
   logic [rtt_pkg::ROW_W-1:0]      fill_row_ff, fill_row_in;
   logic [rtt_pkg::COL_W-1:0]      fill_col_ff, fill_col_in;
   logic                           fill_bank_ff, fill_bank_in;
   logic                           drain_pending_ff, drain_pending_in;
   logic [rtt_pkg::DRAIN_W-1:0]    drain_index_ff, drain_index_in;

   logic [7:0]                     band_store [rtt_pkg::STORE_BYTES];
   logic [7:0]                     rd_data_ff;
   logic                           rd_valid_ff;
   logic                           rd_last_ff;
   logic                           rsp_valid_ff;
   rtt_pkg::rsp_type               rsp_data_ff;

   logic [rtt_pkg::TILES_W-1:0]    tiles_eff;
   logic [rtt_pkg::BAND_LEN_W-1:0] band_len;
   logic [rtt_pkg::BAND_LEN_W-1:0] drain_count;
   logic [rtt_pkg::TILES_W-1:0]    tile_count;
   logic                           drain_last;
   logic                           s1_move;
   logic                           s1_free;
   logic                           accept;
   logic                           rd_en;
   logic                           wr_en;
   logic                           col_end, tile_end, row_end;
   logic [rtt_pkg::ADDR_W-1:0]     wr_addr, rd_addr;

   // effective tile count, saturated to 1..max
   always_comb begin
      if (tiles_across_ff == '0) begin
         tiles_eff = rtt_pkg::TILES_W'(1);
      end else if (rtt_pkg::TILES_W'(tiles_across_ff) >
                   rtt_pkg::TILES_W'(rtt_pkg::MAX_TILES_ACROSS)) begin
         tiles_eff = rtt_pkg::TILES_W'(rtt_pkg::MAX_TILES_ACROSS);
      end else begin
         tiles_eff = rtt_pkg::TILES_W'(tiles_across_ff);
      end
   end

   assign band_len    = rtt_pkg::BAND_LEN_W'(tiles_eff)
                        * rtt_pkg::BAND_LEN_W'(rtt_pkg::TILE_BYTES);
   assign drain_count = rtt_pkg::BAND_LEN_W'(drain_index_ff) + rtt_pkg::BAND_LEN_W'(1);
   assign drain_last  = drain_count >= band_len;

   // the read register only takes a new byte when it is empty or moving on
   assign s1_move   = !rsp_valid_ff || !rsp_stall;
   assign s1_free   = !rd_valid_ff || s1_move;
   assign req_stall = !s1_free;
   assign accept    = req_valid && !req_stall;
   assign rd_en     = accept && drain_pending_ff;
   assign wr_en     = accept && (req_data.cmd == rtt_pkg::CMD_DATA);

   assign wr_addr = {fill_bank_ff, fill_tile_ff, fill_row_ff, fill_col_ff};
   assign rd_addr = {~fill_bank_ff, drain_index_ff};

   assign tile_count = rtt_pkg::TILES_W'(fill_tile_ff) + rtt_pkg::TILES_W'(1);
   assign col_end    = fill_col_ff == rtt_pkg::COL_W'(rtt_pkg::TILE_ROW_BYTES - 1);
   assign tile_end   = tile_count >= tiles_eff;
   assign row_end    = fill_row_ff == rtt_pkg::ROW_W'(rtt_pkg::TILE_ROWS - 1);

   always_comb begin
      fill_tile_in     = fill_tile_ff;
      fill_row_in      = fill_row_ff;
      fill_col_in      = fill_col_ff;
      fill_bank_in     = fill_bank_ff;
      drain_pending_in = drain_pending_ff;
      drain_index_in   = drain_index_ff;
      // drain pull comes first, a completed band then overrides it
      if (rd_en) begin
         if (drain_last) begin
            drain_pending_in = 1'b0;
            drain_index_in   = '0;
         end else begin
            drain_index_in = drain_index_ff + rtt_pkg::DRAIN_W'(1);
         end
      end
      if (wr_en) begin
         if (!col_end) begin
            fill_col_in = fill_col_ff + rtt_pkg::COL_W'(1);
         end else begin
            fill_col_in = '0;
            if (!tile_end) begin
               fill_tile_in = fill_tile_ff + rtt_pkg::TILE_W'(1);
            end else begin
               fill_tile_in = '0;
               if (!row_end) begin
                  fill_row_in = fill_row_ff + rtt_pkg::ROW_W'(1);
               end else begin
                  fill_row_in      = '0;
                  fill_bank_in     = ~fill_bank_ff;
                  drain_pending_in = 1'b1;
                  drain_index_in   = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tiles_across_ff  <= rtt_pkg::TILES_ACROSS_RESET;
         fill_tile_ff     <= '0;
         fill_row_ff      <= '0;
         fill_col_ff      <= '0;
         fill_bank_ff     <= 1'b0;
         drain_pending_ff <= 1'b0;
         drain_index_ff   <= '0;
         rd_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tiles_across_ff <= csr_wr_data;
         end
         fill_tile_ff     <= fill_tile_in;
         fill_row_ff      <= fill_row_in;
         fill_col_ff      <= fill_col_in;
         fill_bank_ff     <= fill_bank_in;
         drain_pending_ff <= drain_pending_in;
         drain_index_ff   <= drain_index_in;
         if (s1_free) begin
            rd_valid_ff <= rd_en;
         end
         if (s1_move) begin
            rsp_valid_ff <= rd_valid_ff;
         end
      end
   end

   // band memory: write the filling bank, read the draining bank
   always_ff @(posedge clock) begin
      if (wr_en) begin
         band_store[wr_addr] <= req_data.pixel_byte;
      end
      if (rd_en) begin
         rd_data_ff <= band_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_last_ff <= drain_last;
      end
      if (s1_move && rd_valid_ff) begin
         rsp_data_ff.out_byte  <= rd_data_ff;
         rsp_data_ff.band_last <= rd_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_no_read_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && !s1_move) |-> !rd_en)
      else $error("read register overwritten while held");

   a_band_done_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (wr_en && col_end && tile_end && row_end) |=>
      (drain_pending_ff && drain_index_ff == '0 && fill_bank_ff != $past(fill_bank_ff)))
      else $error("completed band did not start a drain");

   a_rsp_from_read_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(rd_valid_ff))
      else $error("result shown without a read behind it");
`endif

endmodule
